### rtl/filename_to_fcb_parser_assert.svh
// assertion macros for the 8.3 filename parser
`ifndef FILENAME_TO_FCB_PARSER_ASSERT_SVH
`define FILENAME_TO_FCB_PARSER_ASSERT_SVH

// same-cycle implication, checked outside reset
`define FCB_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("fcb same-cycle check failed");

// next-cycle implication, checked outside reset
`define FCB_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("fcb next-cycle check failed");

`endif

### rtl/fcb_pkg.sv
// shared types, constants and helper functions of the 8.3 filename parser
`default_nettype none

package fcb_pkg;

  localparam int NAME_LEN   = 8;
  localparam int TYPE_LEN   = 3;
  localparam int NAME_SLOTS = 8;
  localparam int TYPE_SLOTS = 3;
  localparam int POS_W      = 4;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_QMARK = 8'h3F;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_EQUAL = 8'h3D;
  localparam logic [7:0] CH_APOS  = 8'h27;
  localparam logic [7:0] CH_QUOTE = 8'h22;

  typedef enum logic [1:0] {
    PH_NAME = 2'd0,
    PH_SKIP = 2'd1,
    PH_TYPE = 2'd2,
    PH_DONE = 2'd3
  } phase_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } fcb_word_t;

  typedef struct packed {
    logic [8*NAME_SLOTS-1:0] name_field;
    logic [8*TYPE_SLOTS-1:0] type_field;
    logic                    ok;
  } fcb_result_t;

  function automatic logic legal_byte(input logic [7:0] c);
    logic bad;
    bad = (c <= CH_SPACE) || (c == CH_COMMA) || (c == CH_SEMI) || (c == CH_COLON) ||
          (c == CH_EQUAL) || (c == CH_APOS) || (c == CH_QUOTE);
    return !bad;
  endfunction

  function automatic logic ends_parse(input logic [7:0] c);
    return (c == CH_NUL) || (c == CH_SPACE);
  endfunction

endpackage

`default_nettype wire

### rtl/fcb_in_stage.sv
// input register stage of the 8.3 filename parser
`default_nettype none

module fcb_in_stage
  import fcb_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire logic [7:0] in_ch,
  input  wire logic      in_last,
  input  wire logic      adv,
  output fcb_word_t      word_q,
  output logic           word_valid
);

  logic      valid_r;
  fcb_word_t word_r;

  assign in_ready   = !valid_r || adv;
  assign word_q     = word_r;
  assign word_valid = valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      valid_r <= 1'b1;
    end else if (adv) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      word_r.ch   <= in_ch;
      word_r.last <= in_last;
    end
  end

endmodule

`default_nettype wire

### rtl/fcb_parser.sv
// parse state and per-byte update logic of the 8.3 filename parser
`default_nettype none

module fcb_parser
  import fcb_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  fire,
  input  wire fcb_word_t word,
  output fcb_result_t res,
  output logic       res_load
);

  phase_t             phase_r, phase_nxt;
  logic [POS_W-1:0]   pos_r, pos_nxt, pos_inc;
  logic               failed_r, failed_nxt;
  logic [7:0]         name_r [NAME_SLOTS];
  logic [7:0]         name_nxt [NAME_SLOTS];
  logic [7:0]         type_r [TYPE_SLOTS];
  logic [7:0]         type_nxt [TYPE_SLOTS];
  logic [7:0]         c;

  assign c        = word.ch;
  assign pos_inc  = pos_r + 1'b1;
  assign res_load = fire && word.last;

  always_comb begin
    phase_nxt  = phase_r;
    pos_nxt    = pos_r;
    failed_nxt = failed_r;
    name_nxt   = name_r;
    type_nxt   = type_r;
    if (fire && !failed_r) begin
      unique case (phase_r)
        PH_SKIP: begin
          if (ends_parse(c)) begin
            phase_nxt = PH_DONE;
          end else if (c == CH_DOT) begin
            phase_nxt = PH_TYPE;
            pos_nxt   = '0;
          end
        end
        PH_NAME: begin
          priority if (ends_parse(c)) begin
            phase_nxt = PH_DONE;
          end else if (c == CH_DOT) begin
            phase_nxt = PH_TYPE;
            pos_nxt   = '0;
          end else if (c == CH_STAR) begin
            for (int k = 0; k < NAME_LEN; k++) begin
              if (POS_W'(k) >= pos_r) name_nxt[k] = CH_QMARK;
            end
            phase_nxt = PH_SKIP;
          end else if (!legal_byte(c)) begin
            failed_nxt = 1'b1;
          end else begin
            for (int k = 0; k < NAME_LEN; k++) begin
              if (POS_W'(k) == pos_r) name_nxt[k] = c;
            end
            pos_nxt = pos_inc;
            if (pos_inc >= POS_W'(NAME_LEN)) phase_nxt = PH_SKIP;
          end
        end
        PH_TYPE: begin
          priority if (ends_parse(c)) begin
            phase_nxt = PH_DONE;
          end else if (c == CH_DOT) begin
            failed_nxt = 1'b1;
          end else if (c == CH_STAR) begin
            for (int k = 0; k < TYPE_LEN; k++) begin
              if (POS_W'(k) >= pos_r) type_nxt[k] = CH_QMARK;
            end
            phase_nxt = PH_DONE;
          end else if (!legal_byte(c)) begin
            failed_nxt = 1'b1;
          end else begin
            for (int k = 0; k < TYPE_LEN; k++) begin
              if (POS_W'(k) == pos_r) type_nxt[k] = c;
            end
            pos_nxt = pos_inc;
            if (pos_inc >= POS_W'(TYPE_LEN)) phase_nxt = PH_DONE;
          end
        end
        PH_DONE: begin
        end
      endcase
    end
  end

  // pack the updated fields, first byte in the top lane
  always_comb begin
    res = '0;
    res.ok = !failed_nxt;
    if (!failed_nxt) begin
      for (int k = 0; k < NAME_SLOTS; k++) begin
        res.name_field[8*(NAME_SLOTS-1-k) +: 8] = name_nxt[k];
      end
      for (int k = 0; k < TYPE_SLOTS; k++) begin
        res.type_field[8*(TYPE_SLOTS-1-k) +: 8] = type_nxt[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || res_load) begin
      phase_r  <= PH_NAME;
      pos_r    <= '0;
      failed_r <= 1'b0;
      for (int k = 0; k < NAME_SLOTS; k++) name_r[k] <= CH_SPACE;
      for (int k = 0; k < TYPE_SLOTS; k++) type_r[k] <= CH_SPACE;
    end else begin
      phase_r  <= phase_nxt;
      pos_r    <= pos_nxt;
      failed_r <= failed_nxt;
      name_r   <= name_nxt;
      type_r   <= type_nxt;
    end
  end

endmodule

`default_nettype wire

### rtl/fcb_out_stage.sv
// result register stage of the 8.3 filename parser
`default_nettype none

module fcb_out_stage
  import fcb_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   res_load,
  input  wire fcb_result_t res,
  output logic        out_valid,
  input  wire logic   out_ready,
  output logic [8*NAME_SLOTS-1:0] out_name_field,
  output logic [8*TYPE_SLOTS-1:0] out_type_field,
  output logic        out_ok
);

  logic        valid_r;
  fcb_result_t res_r;

  assign out_valid      = valid_r;
  assign out_name_field = res_r.name_field;
  assign out_type_field = res_r.type_field;
  assign out_ok         = res_r.ok;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (res_load) begin
      valid_r <= 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      res_r <= res;
    end
  end

endmodule

`default_nettype wire

### rtl/filename_to_fcb_parser.sv
// top level of the 8.3 filename parser
// usage:
//   in_ch/in_last arrive one word per cycle on a valid/ready channel; each word
//   is one upper-case filename byte, in_last marks the final byte of an argument
//   out_name_field/out_type_field/out_ok leave on a valid/ready channel, one
//   word per argument, produced by the byte marked last
//   order: a byte is registered on entry and parsed from that register; out_valid
//   for a last byte rises as the result register takes the parsed fields
//   throughput: one byte per cycle while no last byte is held back, set by the
//   single input register feeding the parse logic and the result register
//   stall: while a result waits in the output register, non-last bytes keep
//   flowing; a last byte holds in the input register until the result is taken
//   reset: rst_n low for one cycle empties both registers and returns the
//   parse state to the name phase with space-filled fields; no clearing pass
`default_nettype none

module filename_to_fcb_parser
  import fcb_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_ch,
  input  wire logic       in_last,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [63:0]     out_name_field,
  output logic [23:0]     out_type_field,
  output logic            out_ok
);

`include "filename_to_fcb_parser_assert.svh"

  fcb_word_t   word_q;
  logic        word_valid;
  logic        adv;
  logic        res_load;
  fcb_result_t res;

  // a last byte needs the result register free or draining
  assign adv = word_valid && (!word_q.last || !out_valid || out_ready);

  fcb_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_ch      (in_ch),
    .in_last    (in_last),
    .adv        (adv),
    .word_q     (word_q),
    .word_valid (word_valid)
  );

  fcb_parser u_parse (
    .clk      (clk),
    .rst_n    (rst_n),
    .fire     (adv),
    .word     (word_q),
    .res      (res),
    .res_load (res_load)
  );

  fcb_out_stage u_out (
    .clk            (clk),
    .rst_n          (rst_n),
    .res_load       (res_load),
    .res            (res),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_name_field (out_name_field),
    .out_type_field (out_type_field),
    .out_ok         (out_ok)
  );

  `FCB_ASSERT_NOW(a_fail_zero, out_valid && !out_ok, out_name_field == '0 && out_type_field == '0)
  `FCB_ASSERT_NOW(a_no_overwrite, res_load, !out_valid || out_ready)
  `FCB_ASSERT_NEXT(a_load_shows, res_load, out_valid)
  `FCB_ASSERT_NOW(a_held_last, word_valid && word_q.last && out_valid && !out_ready, !in_ready)

endmodule

`default_nettype wire

### bench/tb.sv
// self-checking testbench of the 8.3 filename parser: directed, random and stall tests
`timescale 1ns / 1ps

module tb;
  import fcb_pkg::*;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_ch = 8'h00;
  logic        in_last = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [63:0] out_name_field;
  logic [23:0] out_type_field;
  logic        out_ok;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_request = 0;
  int hold_left = 0;
  int bytes_sent = 0;
  int error_count = 0;

  phase_t     parse_phase;
  logic [3:0] parse_pos;
  logic [7:0] name_buf [NAME_SLOTS];
  logic [7:0] type_buf [TYPE_SLOTS];
  logic       parse_failed;

  fcb_result_t fcb_expected[$];
  logic [7:0]  arg_bytes[$];

  filename_to_fcb_parser i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_ch          (in_ch),
    .in_last        (in_last),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_name_field (out_name_field),
    .out_type_field (out_type_field),
    .out_ok         (out_ok)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("Verification failed");
    $finish;
  end

  function automatic logic fcb_char_ok(input logic [7:0] c);
    logic ok;
    case (c)
      CH_COMMA, CH_SEMI, CH_COLON, CH_EQUAL, CH_APOS, CH_QUOTE: ok = 1'b0;
      default: ok = (c > CH_SPACE);
    endcase
    return ok;
  endfunction

  task automatic clear_parse();
    int k;
    parse_phase = PH_NAME;
    parse_pos = '0;
    parse_failed = 1'b0;
    for (k = 0; k < NAME_SLOTS; k++) name_buf[k] = CH_SPACE;
    for (k = 0; k < TYPE_SLOTS; k++) type_buf[k] = CH_SPACE;
  endtask

  // expected outcome of one accepted word
  task automatic parse_byte(input logic [7:0] c, input logic last);
    int k;
    fcb_result_t res;
    if (!parse_failed && parse_phase != PH_DONE) begin
      case (parse_phase)
        PH_SKIP: begin
          if (c == CH_NUL || c == CH_SPACE) begin
            parse_phase = PH_DONE;
          end else if (c == CH_DOT) begin
            parse_phase = PH_TYPE;
            parse_pos = '0;
          end
        end
        PH_NAME: begin
          if (c == CH_NUL || c == CH_SPACE) begin
            parse_phase = PH_DONE;
          end else if (c == CH_DOT) begin
            parse_phase = PH_TYPE;
            parse_pos = '0;
          end else if (c == CH_STAR) begin
            for (k = parse_pos; k < NAME_LEN; k++) name_buf[k] = CH_QMARK;
            parse_phase = PH_SKIP;
          end else if (!fcb_char_ok(c)) begin
            parse_failed = 1'b1;
          end else begin
            name_buf[parse_pos] = c;
            parse_pos++;
            if (parse_pos >= NAME_LEN) parse_phase = PH_SKIP;
          end
        end
        default: begin
          if (c == CH_NUL || c == CH_SPACE) begin
            parse_phase = PH_DONE;
          end else if (c == CH_DOT || (c != CH_STAR && !fcb_char_ok(c))) begin
            parse_failed = 1'b1;
          end else if (c == CH_STAR) begin
            for (k = parse_pos; k < TYPE_LEN; k++) type_buf[k] = CH_QMARK;
            parse_phase = PH_DONE;
          end else begin
            type_buf[parse_pos] = c;
            parse_pos++;
            if (parse_pos >= TYPE_LEN) parse_phase = PH_DONE;
          end
        end
      endcase
    end
    if (last) begin
      res.name_field = '0;
      res.type_field = '0;
      if (!parse_failed) begin
        for (k = 0; k < NAME_SLOTS; k++) res.name_field = (res.name_field << 8) | name_buf[k];
        for (k = 0; k < TYPE_SLOTS; k++) res.type_field = (res.type_field << 8) | type_buf[k];
      end
      res.ok = !parse_failed;
      fcb_expected.push_back(res);
      clear_parse();
    end
  endtask

  // receiver: random stalls plus an optional long hold-off
  always @(posedge clk) begin
    if (hold_request != 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left--;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin : result_check
    fcb_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (fcb_expected.size() == 0) begin
        $error("unexpected result word: name_field %h type_field %h ok %b",
               out_name_field, out_type_field, out_ok);
        error_count++;
      end else begin
        want = fcb_expected.pop_front();
        if (out_name_field !== want.name_field) begin
          $error("name_field: expected %h, actual %h", want.name_field, out_name_field);
          error_count++;
        end
        if (out_type_field !== want.type_field) begin
          $error("type_field: expected %h, actual %h", want.type_field, out_type_field);
          error_count++;
        end
        if (out_ok !== want.ok) begin
          $error("ok: expected %b, actual %b", want.ok, out_ok);
          error_count++;
        end
      end
    end
  end

  task automatic send_byte(input logic [7:0] c, input logic last);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_ch <= c;
    in_last <= last;
    do @(posedge clk); while (!in_ready);
    bytes_sent++;
    parse_byte(c, last);
  endtask

  task automatic send_argument();
    int k;
    for (k = 0; k < arg_bytes.size(); k++) send_byte(arg_bytes[k], k == arg_bytes.size() - 1);
  endtask

  task automatic send_text(input string s);
    int k;
    arg_bytes.delete();
    for (k = 0; k < s.len(); k++) arg_bytes.push_back(s[k]);
    send_argument();
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (fcb_expected.size() != 0);
  endtask

  function automatic logic [7:0] pick_char(input logic broken);
    logic [7:0] c;
    if (broken && $urandom_range(3) == 0) begin
      case ($urandom_range(7))
        0: c = CH_COMMA;
        1: c = CH_SEMI;
        2: c = CH_COLON;
        3: c = CH_EQUAL;
        4: c = CH_APOS;
        5: c = CH_QUOTE;
        6: c = CH_DOT;
        default: c = 8'($urandom_range(1, 31));
      endcase
    end else if ($urandom_range(15) == 0) begin
      c = CH_STAR;
    end else begin
      do begin
        if ($urandom_range(3) != 0) c = 8'($urandom_range(8'h21, 8'h7E));
        else c = 8'($urandom_range(255));
      end while (!fcb_char_ok(c) || c == CH_DOT || c == CH_STAR);
    end
    return c;
  endfunction

  // mostly well-formed names, some with bad bytes, some pure noise
  task automatic build_argument();
    int kind, n, k;
    logic broken;
    arg_bytes.delete();
    kind = $urandom_range(99);
    broken = (kind < 20);
    if (kind >= 85) begin
      n = $urandom_range(1, 12);
      for (k = 0; k < n; k++) arg_bytes.push_back(8'($urandom_range(255)));
    end else begin
      n = $urandom_range(0, 10);
      for (k = 0; k < n; k++) arg_bytes.push_back(pick_char(broken));
      if ($urandom_range(3) != 0) begin
        arg_bytes.push_back(CH_DOT);
        n = $urandom_range(0, 4);
        for (k = 0; k < n; k++) arg_bytes.push_back(pick_char(broken));
      end
      if ($urandom_range(3) == 0) begin
        arg_bytes.push_back($urandom_range(1) ? CH_NUL : CH_SPACE);
        n = $urandom_range(0, 3);
        for (k = 0; k < n; k++) arg_bytes.push_back(8'($urandom_range(255)));
      end
      if (arg_bytes.size() == 0) arg_bytes.push_back(CH_NUL);
    end
  endtask

  task automatic test_directed();
    send_text("*.*");
    send_text("123456789.A*");
    arg_bytes.delete();
    arg_bytes.push_back(CH_NUL);
    send_argument();
    send_text(" ");
    arg_bytes.delete();
    arg_bytes.push_back(8'hFF);
    arg_bytes.push_back(8'h7F);
    arg_bytes.push_back(8'h21);
    send_argument();
    send_text("..");
    arg_bytes.delete();
    arg_bytes.push_back("A");
    arg_bytes.push_back(8'h01);
    send_argument();
    send_text("=");
  endtask

  task automatic test_random_traffic(input int idle_pct, input int stall_pct, input int count);
    int start;
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    start = bytes_sent;
    while (bytes_sent - start < count) begin
      build_argument();
      send_argument();
    end
  endtask

  // receiver blocked long enough that the input side backs up
  task automatic test_output_hold();
    int k;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_request = 400;
    for (k = 0; k < 40; k++) begin
      build_argument();
      send_argument();
    end
  endtask

  task automatic test_drain_pause();
    int k;
    send_idle_pct = 20;
    recv_stall_pct = 20;
    for (k = 0; k < 10; k++) begin
      build_argument();
      send_argument();
    end
    wait_for_results();
    for (k = 0; k < 10; k++) begin
      build_argument();
      send_argument();
    end
  endtask

  initial begin
    clear_parse();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_random_traffic(0, 0, 330);
    test_random_traffic(69, 0, 330);
    test_random_traffic(0, 69, 330);
    test_random_traffic(33, 33, 330);
    test_output_hold();
    test_drain_pause();
    wait_for_results();
    repeat (8) @(posedge clk);
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
